// ----- hw/rtl/bta_pkg.sv -----
package bta_pkg;

	localparam int POOL_BYTES  = 65536;
	localparam int ROUND_MASK  = 15;
	localparam int POOL_EFF    = (POOL_BYTES / 4) * 4;
	localparam int WORDS       = POOL_EFF / 4;
	localparam int IDX_W       = $clog2(WORDS);
	localparam int HDR_W       = 18;
	localparam int VAL_W       = HDR_W + 1;
	localparam int POS_W       = 18;
	localparam int CNT_W       = 18;
	localparam int OFF_W       = 16;
	localparam int RMASK       = ROUND_MASK | 3;
	localparam int BUDGET_INIT = 8 * WORDS + 64;

	typedef logic signed [VAL_W-1:0] hval_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	localparam pos_t  POOL_POS = pos_t'(POOL_EFF);
	localparam hval_t W0_RESET = hval_t'(-(POOL_EFF - 4));
	localparam cnt_t  BUDGET0  = cnt_t'(BUDGET_INIT);

	typedef enum logic [2:0] {
		ST_NOTHING   = 3'd0,
		ST_ALLOC     = 3'd1,
		ST_FREED     = 3'd2,
		ST_UNCHANGED = 3'd3,
		ST_MOVED     = 3'd4,
		ST_SHRUNK    = 3'd5,
		ST_OOM       = 3'd6
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHK_RD,
		S_CHK_WT,
		S_DECIDE,
		S_SHR_W2,
		S_A_INIT,
		S_L1_RD,
		S_L1_WT,
		S_A_CHK,
		S_SPLIT_W2,
		S_L2_RD,
		S_L2_WT,
		S_M_RD0,
		S_M_WT0,
		S_M_RD,
		S_M_WT,
		S_M_WR,
		S_A_OK,
		S_A_FAIL,
		S_DONE
	} state_t;

	typedef enum logic {
		MR_TAIL,
		MR_L2
	} mret_t;

	function automatic hval_t round_size(input logic [OFF_W-1:0] s);
		logic [OFF_W:0] t;
		t = {1'b0, s} + (OFF_W+1)'(RMASK);
		t = t & ~(OFF_W+1)'(RMASK);
		return hval_t'({{(VAL_W-OFF_W-1){1'b0}}, t});
	endfunction

endpackage

// ----- hw/rtl/bta_req_if.sv -----
interface bta_req_if;
	logic        valid;
	logic        ready;
	logic        has_block;
	logic [15:0] block_offset;
	logic [15:0] new_size;

	modport source (output valid, has_block, block_offset, new_size, input ready);
	modport sink (input valid, has_block, block_offset, new_size, output ready);
endinterface

// ----- hw/rtl/bta_rsp_if.sv -----
interface bta_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        result_valid;
	logic [15:0] result_offset;
	logic [15:0] copy_from_offset;
	logic [15:0] copy_bytes;

	modport source (output valid, status, result_valid, result_offset, copy_from_offset,
		copy_bytes, input ready);
	modport sink (input valid, status, result_valid, result_offset, copy_from_offset,
		copy_bytes, output ready);
endinterface

// ----- hw/rtl/bta_ram.sv -----
module bta_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hw/rtl/boundary_tag_pool_allocator.sv -----
// channel | role   | payload
// req     | sink   | has_block, block_offset, new_size
// rsp     | source | status, result_valid, result_offset, copy_from_offset, copy_bytes
//
// every header read goes through the single header memory as an issue state and a use state
// a request on an existing block first walks the chain from offset zero, one read a segment
// allocation then walks from the cursor, one read a segment plus a read and a write per merged free segment
// a finished result sits in an output register; the next item is taken while it waits
// reset holds word zero's initial value in one flag, so no clearing pass is needed
module boundary_tag_pool_allocator (
	input logic   clk,
	input logic   arst_n,
	bta_req_if.sink   req,
	bta_rsp_if.source rsp
);
	import bta_pkg::*;

	state_t  state_q, state_d;
	pos_t    p_q, p_d, q_q, q_d, mp_q, mp_d, mnxt_q, mnxt_d;
	hval_t   h_q, h_d, sp_q, sp_d, ss_q, ss_d, mh_q, mh_d, old_q, old_d;
	cnt_t    trav_q, trav_d, budget_q, budget_d;
	logic [OFF_W-1:0] cursor_q, cursor_d, hdr_q, hdr_d, boff_q, boff_d, nsz_q, nsz_d;
	mret_t   mret_q, mret_d;
	logic    amove_q, amove_d;
	status_t status_q, status_d;
	logic    rv_q, rv_d;
	logic [OFF_W-1:0] roff_q, roff_d, cfrom_q, cfrom_d, cbytes_q, cbytes_d;

	logic    out_v_q;
	status_t out_status_q;
	logic    out_rv_q;
	logic [OFF_W-1:0] out_roff_q, out_cfrom_q, out_cbytes_q;
	logic    load_out;

	logic    w0v_q;
	logic    rd_en, wr_en, ram_we;
	pos_t    rd_pos, wr_pos;
	hval_t   wr_val, rdata_v;
	logic [HDR_W-1:0] ram_rdata;
	logic    rd_oob_s1, rd_zero_s1;

	bta_ram #(.WIDTH(HDR_W), .DEPTH(WORDS)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_pos[IDX_W+1:2]),
		.wdata (wr_val[HDR_W-1:0]),
		.re    (rd_en),
		.raddr (rd_pos[IDX_W+1:2]),
		.rdata (ram_rdata)
	);

	assign ram_we = wr_en && (wr_pos < POOL_POS);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_oob_s1  <= rd_pos >= POOL_POS;
			rd_zero_s1 <= rd_pos[POS_W-1:2] == '0;
		end
	end

	always_comb begin
		if (rd_oob_s1) begin
			rdata_v = '0;
		end else if (rd_zero_s1 && !w0v_q) begin
			rdata_v = W0_RESET;
		end else begin
			rdata_v = hval_t'({ram_rdata[HDR_W-1], ram_rdata});
		end
	end

	assign req.ready = state_q == S_IDLE;
	assign load_out = state_q == S_DONE && (!out_v_q || rsp.ready);

	always_comb begin
		hval_t v, negh, rr, ssh, nsv;
		pos_t  pn, mag;
		cnt_t  tn;
		state_d  = state_q;
		p_d = p_q; q_d = q_q; mp_d = mp_q; mnxt_d = mnxt_q;
		h_d = h_q; sp_d = sp_q; ss_d = ss_q; mh_d = mh_q; old_d = old_q;
		trav_d = trav_q; budget_d = budget_q; cursor_d = cursor_q;
		hdr_d = hdr_q; boff_d = boff_q; nsz_d = nsz_q;
		mret_d = mret_q; amove_d = amove_q;
		status_d = status_q; rv_d = rv_q; roff_d = roff_q;
		cfrom_d = cfrom_q; cbytes_d = cbytes_q;
		rd_en = 1'b0; rd_pos = '0;
		wr_en = 1'b0; wr_pos = '0; wr_val = '0;
		v = rdata_v;
		negh = -v;
		rr = round_size(nsz_q);
		ssh = rr + hval_t'(4);
		nsv = hval_t'({{(VAL_W-OFF_W){1'b0}}, nsz_q});
		pn = '0; mag = '0; tn = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					status_d = ST_NOTHING; rv_d = 1'b0; roff_d = '0;
					cfrom_d = '0; cbytes_d = '0;
					boff_d = req.block_offset; nsz_d = req.new_size;
					hdr_d = req.block_offset - OFF_W'(4);
					q_d = '0;
					amove_d = req.has_block;
					if (!req.has_block) begin
						state_d = (req.new_size == '0) ? S_DONE : S_A_INIT;
					end else begin
						state_d = (req.block_offset < OFF_W'(4)) ? S_DONE : S_CHK_RD;
					end
				end
			end
			S_CHK_RD: begin
				rd_en = 1'b1; rd_pos = q_q;
				state_d = S_CHK_WT;
			end
			S_CHK_WT: begin
				mag = (v < 0) ? negh[POS_W-1:0] : v[POS_W-1:0];
				pn = q_q + mag + pos_t'(4);
				if (q_q == pos_t'(hdr_q)) begin
					old_d = v;
					state_d = (v > 0) ? S_DECIDE : S_DONE;
				end else if (q_q > pos_t'(hdr_q) || v == 0 || pn >= POOL_POS) begin
					state_d = S_DONE;
				end else begin
					q_d = pn;
					state_d = S_CHK_RD;
				end
			end
			S_DECIDE: begin
				if (nsz_q == '0) begin
					wr_en = 1'b1; wr_pos = pos_t'(hdr_q); wr_val = -old_q;
					status_d = ST_FREED;
					state_d = S_DONE;
				end else if (nsv == old_q || (nsv > old_q && rr <= old_q)) begin
					status_d = ST_UNCHANGED; rv_d = 1'b1; roff_d = boff_q;
					state_d = S_DONE;
				end else if (nsv > old_q) begin
					state_d = S_A_INIT;
				end else begin
					status_d = ST_SHRUNK; rv_d = 1'b1; roff_d = boff_q;
					ss_d = ssh;
					if (old_q > ssh) begin
						wr_en = 1'b1; wr_pos = pos_t'(hdr_q); wr_val = rr;
						state_d = S_SHR_W2;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SHR_W2: begin
				wr_en = 1'b1;
				wr_pos = pos_t'(hdr_q) + ss_q[POS_W-1:0];
				wr_val = ss_q - old_q;
				state_d = S_DONE;
			end
			S_A_INIT: begin
				sp_d = rr; ss_d = ssh;
				trav_d = '0; budget_d = BUDGET0;
				p_d = pos_t'(cursor_q);
				state_d = S_L1_RD;
			end
			S_L1_RD: begin
				rd_en = 1'b1; rd_pos = p_q;
				state_d = S_L1_WT;
			end
			S_L1_WT: begin
				h_d = v;
				if (v > 0) begin
					tn = trav_q + v[CNT_W-1:0] + cnt_t'(4);
					pn = p_q + v[POS_W-1:0] + pos_t'(4);
					if (tn >= cnt_t'(POOL_EFF) || budget_q == '0) begin
						state_d = S_A_FAIL;
					end else begin
						trav_d = tn; budget_d = budget_q - cnt_t'(1);
						p_d = (pn >= POOL_POS) ? '0 : pn;
						state_d = S_L1_RD;
					end
				end else begin
					state_d = S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (sp_q == -h_q) begin
					wr_en = 1'b1; wr_pos = p_q; wr_val = sp_q;
					roff_d = p_q[OFF_W-1:0] + OFF_W'(4);
					state_d = S_A_OK;
				end else if (ss_q < -h_q) begin
					wr_en = 1'b1; wr_pos = p_q; wr_val = sp_q;
					state_d = S_SPLIT_W2;
				end else begin
					mp_d = p_q; mret_d = MR_L2;
					state_d = S_M_RD0;
				end
			end
			S_SPLIT_W2: begin
				wr_en = 1'b1;
				wr_pos = p_q + ss_q[POS_W-1:0];
				wr_val = ss_q + h_q;
				roff_d = p_q[OFF_W-1:0] + OFF_W'(4);
				mp_d = p_q + ss_q[POS_W-1:0];
				mret_d = MR_TAIL;
				state_d = S_M_RD0;
			end
			S_L2_RD: begin
				rd_en = 1'b1; rd_pos = p_q;
				state_d = S_L2_WT;
			end
			S_L2_WT: begin
				if (v < 0 && negh <= ss_q && negh != sp_q) begin
					tn = trav_q + negh[CNT_W-1:0] + cnt_t'(4);
					pn = p_q + negh[POS_W-1:0] + pos_t'(4);
					if (tn >= cnt_t'(POOL_EFF) || budget_q == '0) begin
						state_d = S_A_FAIL;
					end else begin
						trav_d = tn; budget_d = budget_q - cnt_t'(1);
						if (pn >= POOL_POS) begin
							p_d = '0; mp_d = '0; mret_d = MR_L2;
							state_d = S_M_RD0;
						end else begin
							p_d = pn;
							state_d = S_L2_RD;
						end
					end
				end else if (budget_q == '0) begin
					state_d = S_A_FAIL;
				end else begin
					budget_d = budget_q - cnt_t'(1);
					state_d = S_L1_RD;
				end
			end
			S_M_RD0: begin
				rd_en = 1'b1; rd_pos = mp_q;
				state_d = S_M_WT0;
			end
			S_M_WT0: begin
				mh_d = v;
				pn = mp_q + negh[POS_W-1:0] + pos_t'(4);
				mnxt_d = pn;
				if (v >= 0 || pn >= POOL_POS) begin
					if (mret_q == MR_TAIL) begin
						cursor_d = mp_q[OFF_W-1:0];
					end
					state_d = (mret_q == MR_TAIL) ? S_A_OK : S_L2_RD;
				end else begin
					state_d = S_M_RD;
				end
			end
			S_M_RD: begin
				rd_en = 1'b1; rd_pos = mnxt_q;
				state_d = S_M_WT;
			end
			S_M_WT: begin
				if (v < 0) begin
					mh_d = mh_q + v - hval_t'(4);
					state_d = S_M_WR;
				end else begin
					cursor_d = mp_q[OFF_W-1:0];
					state_d = (mret_q == MR_TAIL) ? S_A_OK : S_L2_RD;
				end
			end
			S_M_WR: begin
				negh = -mh_q;
				wr_en = 1'b1; wr_pos = mp_q; wr_val = mh_q;
				pn = mp_q + negh[POS_W-1:0] + pos_t'(4);
				mnxt_d = pn;
				if (pn >= POOL_POS) begin
					cursor_d = mp_q[OFF_W-1:0];
					state_d = (mret_q == MR_TAIL) ? S_A_OK : S_L2_RD;
				end else begin
					state_d = S_M_RD;
				end
			end
			S_A_OK: begin
				rv_d = 1'b1;
				if (amove_q) begin
					wr_en = 1'b1; wr_pos = pos_t'(hdr_q); wr_val = -old_q;
					status_d = ST_MOVED;
					cfrom_d = boff_q;
					cbytes_d = old_q[OFF_W-1:0];
				end else begin
					status_d = ST_ALLOC;
				end
				state_d = S_DONE;
			end
			S_A_FAIL: begin
				status_d = ST_OOM; rv_d = 1'b0; roff_d = '0;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			w0v_q    <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			if (ram_we && wr_pos[POS_W-1:2] == '0) begin
				w0v_q <= 1'b1;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q <= p_d; q_q <= q_d; mp_q <= mp_d; mnxt_q <= mnxt_d;
		h_q <= h_d; sp_q <= sp_d; ss_q <= ss_d; mh_q <= mh_d; old_q <= old_d;
		trav_q <= trav_d; budget_q <= budget_d;
		hdr_q <= hdr_d; boff_q <= boff_d; nsz_q <= nsz_d;
		mret_q <= mret_d; amove_q <= amove_d;
		status_q <= status_d; rv_q <= rv_d; roff_q <= roff_d;
		cfrom_q <= cfrom_d; cbytes_q <= cbytes_d;
		if (load_out) begin
			out_status_q <= status_q;
			out_rv_q     <= rv_q;
			out_roff_q   <= roff_q;
			out_cfrom_q  <= cfrom_q;
			out_cbytes_q <= cbytes_q;
		end
	end

	assign rsp.valid            = out_v_q;
	assign rsp.status           = out_status_q;
	assign rsp.result_valid     = out_rv_q;
	assign rsp.result_offset    = out_roff_q;
	assign rsp.copy_from_offset = out_cfrom_q;
	assign rsp.copy_bytes       = out_cbytes_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != S_IDLE)
		else $error("accepted item left the sequencer idle");

	a_result_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.result_valid |-> (out_status_q == ST_ALLOC ||
		out_status_q == ST_UNCHANGED || out_status_q == ST_MOVED ||
		out_status_q == ST_SHRUNK))
		else $error("block offset reported with a status that has none");

	a_copy_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.copy_bytes != '0 |-> out_status_q == ST_MOVED)
		else $error("copy length outside a move");

	a_cursor_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q[1:0] == 2'b00)
		else $error("cursor off a header boundary");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_v_q && !rsp.ready |=> state_q == S_DONE)
		else $error("result dropped while output register full");

endmodule
